// File: rtl/byte_ring_buffer_unit_defines.svh
// Assertion helpers used by the ring buffer datapath.
// Each expects signals named clk and arst_n in the module that uses it.
`ifndef BYTE_RING_BUFFER_UNIT_DEFINES_SVH
`define BYTE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BRB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("byte ring buffer check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define BRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("byte ring buffer check failed");

`endif

// File: rtl/brb_pkg.sv
package brb_pkg;

	localparam int OP_W     = 3;
	localparam int LEN_W    = 7;
	localparam int DATA_W   = 8;
	localparam int CNT_W    = 11;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ_START = 3'd0,
		OP_DATA      = 3'd1,
		OP_DEQUEUE   = 3'd2,
		OP_PEEK      = 3'd3,
		OP_ADV_WRITE = 3'd4,
		OP_ADV_READ  = 3'd5,
		OP_CLEAR     = 3'd6,
		OP_INVALID   = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_REJECT     = 2'd1,
		ST_UNEXPECTED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MV_ZERO = 2'd0,
		MV_ONE  = 2'd1,
		MV_LEN  = 2'd2
	} moved_sel_t;

	typedef enum logic {
		S_IDLE   = 1'b0,
		S_STREAM = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       single;
		status_t    status;
		moved_sel_t moved_sel;
		logic       set_pend;
		logic       clr_pend;
		logic       write;
		logic       adv_wr;
		logic       adv_rd;
		logic       clear;
		logic       stream_start;
		logic       issue;
	} brb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ok_free;
		logic ok_used;
		logic len_zero;
		logic pend_zero;
		logic full;
		logic rem_last;
		logic rd_busy;
		logic out_free;
	} brb_stat_t;

endpackage

// File: rtl/byte_ring_buffer_unit.sv
// Byte ring buffer with all-or-nothing block transfers.
// Input beats arrive on the s_ channel: s_tuser carries the opcode (enqueue start,
// data byte, dequeue, peek, advance write, advance read, clear) and s_tdata the
// length and the data byte. Result beats leave on the m_ channel; m_tlast marks the
// final result caused by an input beat, m_tuser tells whether a stored byte is
// present and carries the status, and m_tdata carries the byte, the moved count and
// the occupancy seen after the item.
// Every item but a dequeue or peek that streams bytes gives one result in the cycle
// after it is accepted, and such items can be taken once per cycle while the receiver
// keeps up. A streaming item moves its bytes through the store read register and the
// result register, one byte per cycle while the receiver keeps up, the rate being set
// by the store's single read port; no new item is taken until the stream is done.
// Reset empties the buffer and drops any pending enqueue block; the byte store
// itself is not cleared, so no sweep is needed and items are taken right after reset.
// When the receiver holds m_tready low the result register keeps its beat, the store
// reads pause, and no new input beat is taken until the result is delivered.
module byte_ring_buffer_unit import brb_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] length, [14:7] data_in, [15] zero fill
	input  logic [15:0] s_tdata,
	// [2:0] op
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] data_out, [14:8] moved, [25:15] used_count, [36:26] free_count,
	// [39:37] zero fill
	output logic [39:0] m_tdata,
	// [0] has_data, [2:1] status
	output logic [2:0]  m_tuser,
	output logic        m_tlast
);

	brb_cmd_t            cmd;
	brb_stat_t           stat;
	logic [DATA_W-1:0]   out_data;
	logic                out_has;
	logic [STATUS_W-1:0] out_status;
	logic [LEN_W-1:0]    out_moved;
	logic [CNT_W-1:0]    out_used;
	logic [CNT_W-1:0]    out_free;

	// The controller sequences items and byte streams; the datapath holds the
	// indices, counters, byte store and the result register.
	brb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op   (s_tuser),
		.stat    (stat),
		.cmd     (cmd)
	);

	brb_dpath #(
		.DEPTH    (DEPTH),
		.MAX_BURST(MAX_BURST)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_len    (s_tdata[6:0]),
		.in_data   (s_tdata[14:7]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_has   (out_has),
		.out_last  (m_tlast),
		.out_status(out_status),
		.out_moved (out_moved),
		.out_used  (out_used),
		.out_free  (out_free)
	);

	// Pack the result beat, lowest field first.
	assign m_tdata = {3'b000, out_free, out_used, out_moved, out_data};
	assign m_tuser = {out_status, out_has};

endmodule

// File: rtl/brb_ram.sv
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/brb_ctrl.sv
module brb_ctrl import brb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   in_op,
	input  brb_stat_t         stat,
	output brb_cmd_t          cmd
);

	state_t state_q;
	state_t state_d;
	op_t    op;
	logic   accept;

	assign op = op_t'(in_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.status    = ST_OK;
		cmd.moved_sel = MV_ZERO;
		in_ready = 1'b0;
		accept   = 1'b0;
		case (state_q)
			S_IDLE: begin
				// Take a new item only when the read pipe is empty and the
				// output register can be loaded this cycle.
				in_ready = stat.out_free && !stat.rd_busy;
				accept   = in_valid && in_ready;
				if (accept) begin
					cmd.single = 1'b1;
					case (op)
						OP_ENQ_START: begin
							if (stat.ok_free) begin
								cmd.set_pend  = 1'b1;
								cmd.moved_sel = MV_LEN;
							end else begin
								cmd.status = ST_REJECT;
							end
						end
						OP_DATA: begin
							if (stat.pend_zero) begin
								cmd.status = ST_UNEXPECTED;
							end else if (stat.full) begin
								cmd.clr_pend = 1'b1;
								cmd.status   = ST_REJECT;
							end else begin
								cmd.write     = 1'b1;
								cmd.moved_sel = MV_ONE;
							end
						end
						OP_DEQUEUE, OP_PEEK: begin
							if (!stat.ok_used) begin
								cmd.status = ST_REJECT;
							end else if (!stat.len_zero) begin
								cmd.single       = 1'b0;
								cmd.stream_start = 1'b1;
								cmd.adv_rd       = (op == OP_DEQUEUE);
								state_d          = S_STREAM;
							end
						end
						OP_ADV_WRITE: begin
							if (stat.ok_free) begin
								cmd.adv_wr    = 1'b1;
								cmd.moved_sel = MV_LEN;
							end else begin
								cmd.status = ST_REJECT;
							end
						end
						OP_ADV_READ: begin
							if (stat.ok_used) begin
								cmd.adv_rd    = 1'b1;
								cmd.moved_sel = MV_LEN;
							end else begin
								cmd.status = ST_REJECT;
							end
						end
						OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
							cmd.status = ST_REJECT;
						end
					endcase
				end
			end
			S_STREAM: begin
				// One read per cycle unless the read stage is full and stalled.
				cmd.issue = !stat.rd_busy || stat.out_free;
				if (cmd.issue && stat.rem_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/brb_dpath.sv
`include "byte_ring_buffer_unit_defines.svh"

module brb_dpath import brb_pkg::*; #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  brb_cmd_t            cmd,
	output brb_stat_t           stat,
	input  logic [LEN_W-1:0]    in_len,
	input  logic [DATA_W-1:0]   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DATA_W-1:0]   out_data,
	output logic                out_has,
	output logic                out_last,
	output logic [STATUS_W-1:0] out_status,
	output logic [LEN_W-1:0]    out_moved,
	output logic [CNT_W-1:0]    out_used,
	output logic [CNT_W-1:0]    out_free
);

	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W;
	localparam int SUM_W = CMP_W + 1;
	localparam logic [CW-1:0]    DEPTH_C = CW'(DEPTH);
	localparam logic [LEN_W-1:0] BURST_C = LEN_W'(MAX_BURST);

	logic [IW-1:0]     rd_idx_q;
	logic [IW-1:0]     wr_idx_q;
	logic [IW-1:0]     srd_idx_q;
	logic [CW-1:0]     occ_q;
	logic [LEN_W-1:0]  pend_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rem_q;
	logic              rd_v_s1;
	logic              last_s1;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_has_q;
	logic              out_last_q;
	status_t           out_status_q;
	logic [LEN_W-1:0]  out_moved_q;

	logic [CW-1:0]     free_w;
	logic [CW-1:0]     len_cw;
	logic [CMP_W-1:0]  len_c;
	logic              burst_ok;
	logic              out_ld;
	logic [DATA_W-1:0] ram_rdata;
	logic [LEN_W-1:0]  moved_w;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] idx,
	                                           input logic [CMP_W-1:0] n);
		logic [SUM_W-1:0] s;
		s = SUM_W'(idx) + SUM_W'(n);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign free_w   = DEPTH_C - occ_q;
	assign len_cw   = CW'(in_len);
	assign len_c    = CMP_W'(in_len);
	assign burst_ok = (in_len <= BURST_C);
	assign out_ld   = !out_valid_q || out_ready;

	assign stat.ok_free   = burst_ok && (len_c <= CMP_W'(free_w));
	assign stat.ok_used   = burst_ok && (len_c <= CMP_W'(occ_q));
	assign stat.len_zero  = (in_len == '0);
	assign stat.pend_zero = (pend_q == '0);
	assign stat.full      = (occ_q == DEPTH_C);
	assign stat.rem_last  = (rem_q == LEN_W'(1));
	assign stat.rd_busy   = rd_v_s1;
	assign stat.out_free  = out_ld;

	always_comb begin
		case (cmd.moved_sel)
			MV_ONE:  moved_w = LEN_W'(1);
			MV_LEN:  moved_w = in_len;
			default: moved_w = '0;
		endcase
	end

	brb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.write),
		.waddr(wr_idx_q),
		.wdata(in_data),
		.re   (cmd.issue),
		.raddr(srd_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			occ_q       <= '0;
			pend_q      <= '0;
			rem_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				occ_q    <= '0;
				pend_q   <= '0;
			end else begin
				if (cmd.write) begin
					wr_idx_q <= wrap_add(wr_idx_q, CMP_W'(1));
					occ_q    <= occ_q + CW'(1);
					pend_q   <= pend_q - LEN_W'(1);
				end else if (cmd.adv_wr) begin
					wr_idx_q <= wrap_add(wr_idx_q, len_c);
					occ_q    <= occ_q + len_cw;
				end else if (cmd.adv_rd) begin
					rd_idx_q <= wrap_add(rd_idx_q, len_c);
					occ_q    <= occ_q - len_cw;
				end
				if (cmd.set_pend) begin
					pend_q <= in_len;
				end else if (cmd.clr_pend) begin
					pend_q <= '0;
				end
			end

			if (cmd.stream_start) begin
				rem_q <= in_len;
			end else if (cmd.issue) begin
				rem_q <= rem_q - LEN_W'(1);
			end

			if (cmd.issue) begin
				rd_v_s1 <= 1'b1;
			end else if (out_ld) begin
				rd_v_s1 <= 1'b0;
			end

			if (cmd.single || (rd_v_s1 && out_ld)) begin
				out_valid_q <= 1'b1;
			end else if (out_ld) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.stream_start) begin
			srd_idx_q <= rd_idx_q;
			len_q     <= in_len;
		end else if (cmd.issue) begin
			srd_idx_q <= wrap_add(srd_idx_q, CMP_W'(1));
		end
		if (cmd.issue) begin
			last_s1 <= stat.rem_last;
		end
		if (cmd.single) begin
			out_data_q   <= '0;
			out_has_q    <= 1'b0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.status;
			out_moved_q  <= moved_w;
		end else if (rd_v_s1 && out_ld) begin
			out_data_q   <= ram_rdata;
			out_has_q    <= 1'b1;
			out_last_q   <= last_s1;
			out_status_q <= ST_OK;
			out_moved_q  <= len_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;
	assign out_has    = out_has_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;
	assign out_moved  = out_moved_q;
	assign out_used   = CNT_W'(occ_q);
	assign out_free   = CNT_W'(free_w);

	`BRB_ASSERT_NOW(a_occ_in_range, 1'b1, occ_q <= DEPTH_C)
	`BRB_ASSERT_NOW(a_single_not_during_read, cmd.single, !rd_v_s1)
	`BRB_ASSERT_NOW(a_issue_has_bytes_left, cmd.issue, rem_q != '0)
	`BRB_ASSERT_NOW(a_write_has_room, cmd.write, occ_q != DEPTH_C)
	`BRB_ASSERT_NEXT(a_issue_fills_read_stage, cmd.issue, rd_v_s1)

endmodule
